@@ hdl/cpht_pkg.sv @@
package cpht_pkg;

   // table and datapath sizes
   localparam int MAX_PLANES  = 8;
   localparam int COORD_BITS  = 32;
   localparam int INDEX_BITS  = 3;
   localparam int COUNT_BITS  = 4;
   localparam int OP_BITS     = 2;
   localparam int DIFF_BITS   = COORD_BITS + 1;
   localparam int PROD_BITS   = COORD_BITS + DIFF_BITS;
   localparam int SUM_BITS    = PROD_BITS + 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QFILL_BITS  = $clog2(QUEUE_DEPTH + 1);

   // item operation codes
   localparam logic [OP_BITS-1:0] OP_WRITE   = 2'd0;
   localparam logic [OP_BITS-1:0] OP_POINT   = 2'd1;
   localparam logic [OP_BITS-1:0] OP_SEGMENT = 2'd2;
   localparam logic [OP_BITS-1:0] OP_NONE    = 2'd3;

   // command handed from front to back
   typedef struct packed {
      logic [OP_BITS-1:0]           op;
      logic [INDEX_BITS-1:0]        index;
      logic [COUNT_BITS-1:0]        count;
      logic signed [COORD_BITS-1:0] ax;
      logic signed [COORD_BITS-1:0] ay;
      logic signed [COORD_BITS-1:0] az;
      logic signed [COORD_BITS-1:0] bx;
      logic signed [COORD_BITS-1:0] by;
      logic signed [COORD_BITS-1:0] bz;
   } cmd_type;

   // command queue status
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

@@ hdl/cpht_front.sv @@
module cpht_front
   import cpht_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic [OP_BITS-1:0]           req_op,
   input  logic [INDEX_BITS-1:0]        req_plane_index,
   input  logic signed [COORD_BITS-1:0] req_ax,
   input  logic signed [COORD_BITS-1:0] req_ay,
   input  logic signed [COORD_BITS-1:0] req_az,
   input  logic signed [COORD_BITS-1:0] req_bx,
   input  logic signed [COORD_BITS-1:0] req_by,
   input  logic signed [COORD_BITS-1:0] req_bz,
   input  logic                         csr_write_en,
   input  logic [COUNT_BITS-1:0]        csr_write_data,
   input  qstat_type                    q_stat,
   output logic                         q_push,
   output cmd_type                      q_data
);

   logic [COUNT_BITS-1:0] plane_count_ff;
   logic [COUNT_BITS-1:0] plane_count_in;
   logic [COUNT_BITS-1:0] active_count;
   logic                  keep;

   // plane count register
   always_comb begin
      plane_count_in = plane_count_ff;
      if (csr_write_en) begin
         plane_count_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_count_ff <= '0;
      end else begin
         plane_count_ff <= plane_count_in;
      end
   end

   // clamp count to the table size
   assign active_count = (int'(plane_count_ff) > MAX_PLANES) ?
                         COUNT_BITS'(MAX_PLANES) : plane_count_ff;

   // classify the beat: unused op code is taken and dropped
   always_comb begin
      unique case (req_op)
         OP_WRITE:   keep = 1'b1;
         OP_POINT:   keep = 1'b1;
         OP_SEGMENT: keep = 1'b1;
         OP_NONE:    keep = 1'b0;
         default:    keep = 1'b0;
      endcase
   end

   assign full   = q_stat.full;
   assign q_push = push && !q_stat.full && keep;

   // command payload
   always_comb begin
      q_data.op    = req_op;
      q_data.index = req_plane_index;
      q_data.count = active_count;
      q_data.ax    = req_ax;
      q_data.ay    = req_ay;
      q_data.az    = req_az;
      q_data.bx    = req_bx;
      q_data.by    = req_by;
      q_data.bz    = req_bz;
   end

endmodule

@@ hdl/cpht_queue.sv @@
module cpht_queue
   import cpht_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      q_push,
   input  cmd_type   q_data,
   input  logic      q_pop,
   output cmd_type   q_head,
   output qstat_type q_stat
);

   cmd_type               store_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QFILL_BITS-1:0] fill_ff, fill_in;

   function automatic logic [QPTR_BITS-1:0] next_ptr(input logic [QPTR_BITS-1:0] ptr);
      if (ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   // pointer and fill updates
   always_comb begin
      wr_ptr_in = q_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = q_pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (q_push && !q_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (q_pop && !q_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (q_push) begin
         store_ff[wr_ptr_ff] <= q_data;
      end
   end

   assign q_head       = store_ff[rd_ptr_ff];
   assign q_stat.full  = (fill_ff == QFILL_BITS'(QUEUE_DEPTH));
   assign q_stat.empty = (fill_ff == '0);

endmodule

@@ hdl/cpht_back.sv @@
module cpht_back
   import cpht_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               q_head,
   input  qstat_type             q_stat,
   output logic                  q_pop,
   output logic                  empty,
   input  logic                  pop,
   output logic                  rsp_hit,
   output logic [INDEX_BITS-1:0] rsp_hit_plane
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_RUN    = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0] state_ff, state_in;

   // plane table
   logic signed [COORD_BITS-1:0] normal_ff [MAX_PLANES][3];
   logic signed [COORD_BITS-1:0] point_ff  [MAX_PLANES][3];

   cmd_type               cmd_ff;
   logic [COUNT_BITS-1:0] issue_ff, issue_in;

   // dot product pipeline
   logic                         d_valid_ff, d_valid_in;
   logic [INDEX_BITS-1:0]        d_index_ff;
   logic signed [COORD_BITS-1:0] n_ff  [3];
   logic signed [DIFF_BITS-1:0]  da_ff [3];
   logic signed [DIFF_BITS-1:0]  db_ff [3];
   logic signed [DIFF_BITS-1:0]  da_in [3];
   logic signed [DIFF_BITS-1:0]  db_in [3];

   logic                         m_valid_ff, m_valid_in;
   logic [INDEX_BITS-1:0]        m_index_ff;
   logic signed [PROD_BITS-1:0]  pa_ff [3];
   logic signed [PROD_BITS-1:0]  pb_ff [3];

   logic                         s_valid_ff, s_valid_in;
   logic [INDEX_BITS-1:0]        s_index_ff;
   logic                         above_a_ff, above_a_in;
   logic                         above_b_ff, above_b_in;
   logic signed [SUM_BITS-1:0]   sum_a, sum_b;

   logic signed [COORD_BITS-1:0] va [3];
   logic signed [COORD_BITS-1:0] vb [3];
   logic [INDEX_BITS-1:0]        rd_index;
   logic                         issue_done;
   logic                         plane_hit;
   logic                         done_hit;
   logic                         done_miss;
   logic                         done;

   logic                  res_hit_ff;
   logic [INDEX_BITS-1:0] res_plane_ff;
   logic                  out_valid_ff, out_valid_in;
   logic                  out_load;
   logic                  out_hit_ff;
   logic [INDEX_BITS-1:0] out_plane_ff;

   // sequencer control
   assign q_pop      = (state_ff == S_IDLE) && !q_stat.empty;
   assign issue_done = (issue_ff == cmd_ff.count);
   assign plane_hit  = (cmd_ff.op == OP_POINT) ? above_a_ff : (above_a_ff != above_b_ff);
   assign done_hit   = (state_ff == S_RUN) && s_valid_ff && plane_hit;
   assign done_miss  = (state_ff == S_RUN) && issue_done && !d_valid_ff && !m_valid_ff &&
                       !done_hit;
   assign done       = done_hit || done_miss;
   assign out_load   = (state_ff == S_FINISH) && (!out_valid_ff || pop);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_pop && (q_head.op == OP_POINT || q_head.op == OP_SEGMENT)) begin
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // issue counter and stage valids
   always_comb begin
      issue_in   = issue_ff;
      d_valid_in = 1'b0;
      if (q_pop) begin
         issue_in = '0;
      end else if ((state_ff == S_RUN) && !issue_done && !done) begin
         issue_in   = issue_ff + 1'b1;
         d_valid_in = 1'b1;
      end
      m_valid_in = d_valid_ff && !done;
      s_valid_in = m_valid_ff && !done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         issue_ff   <= '0;
         d_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         issue_ff   <= issue_in;
         d_valid_ff <= d_valid_in;
         m_valid_ff <= m_valid_in;
         s_valid_ff <= s_valid_in;
      end
   end

   // command latch and table write
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_head;
         if (q_head.op == OP_WRITE && int'(q_head.index) < MAX_PLANES) begin
            normal_ff[q_head.index][0] <= q_head.ax;
            normal_ff[q_head.index][1] <= q_head.ay;
            normal_ff[q_head.index][2] <= q_head.az;
            point_ff[q_head.index][0]  <= q_head.bx;
            point_ff[q_head.index][1]  <= q_head.by;
            point_ff[q_head.index][2]  <= q_head.bz;
         end
      end
   end

   // difference stage: vertex minus plane point
   assign rd_index = issue_ff[INDEX_BITS-1:0];

   always_comb begin
      va[0] = cmd_ff.ax;
      va[1] = cmd_ff.ay;
      va[2] = cmd_ff.az;
      vb[0] = cmd_ff.bx;
      vb[1] = cmd_ff.by;
      vb[2] = cmd_ff.bz;
      for (int c = 0; c < 3; c++) begin
         da_in[c] = DIFF_BITS'(va[c]) - DIFF_BITS'(point_ff[rd_index][c]);
         db_in[c] = DIFF_BITS'(vb[c]) - DIFF_BITS'(point_ff[rd_index][c]);
      end
   end

   always_ff @(posedge clock) begin
      d_index_ff <= rd_index;
      for (int c = 0; c < 3; c++) begin
         n_ff[c]  <= normal_ff[rd_index][c];
         da_ff[c] <= da_in[c];
         db_ff[c] <= db_in[c];
      end
   end

   // product stage
   always_ff @(posedge clock) begin
      m_index_ff <= d_index_ff;
      for (int c = 0; c < 3; c++) begin
         pa_ff[c] <= PROD_BITS'(n_ff[c]) * PROD_BITS'(da_ff[c]);
         pb_ff[c] <= PROD_BITS'(n_ff[c]) * PROD_BITS'(db_ff[c]);
      end
   end

   // sum stage and strict sign test
   always_comb begin
      sum_a = SUM_BITS'(pa_ff[0]) + SUM_BITS'(pa_ff[1]) + SUM_BITS'(pa_ff[2]);
      sum_b = SUM_BITS'(pb_ff[0]) + SUM_BITS'(pb_ff[1]) + SUM_BITS'(pb_ff[2]);
      above_a_in = !sum_a[SUM_BITS-1] && (sum_a != '0);
      above_b_in = !sum_b[SUM_BITS-1] && (sum_b != '0);
   end

   always_ff @(posedge clock) begin
      s_index_ff <= m_index_ff;
      above_a_ff <= above_a_in;
      above_b_ff <= above_b_in;
   end

   // held result of the finished test
   always_ff @(posedge clock) begin
      if (done) begin
         res_hit_ff   <= done_hit;
         res_plane_ff <= done_hit ? s_index_ff : '0;
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_hit_ff   <= res_hit_ff;
         out_plane_ff <= res_plane_ff;
      end
   end

   assign empty         = !out_valid_ff;
   assign rsp_hit       = out_hit_ff;
   assign rsp_hit_plane = out_plane_ff;

endmodule

@@ hdl/cut_plane_halfspace_test.sv @@
// Cut-plane half-space tester. Items enter through a two-beat command queue,
// so the input keeps taking beats while a test runs or a result waits, until
// the queue fills. A plane write updates the table as it leaves the queue. A
// point or segment test walks planes 0 to plane_count-1 through a three-stage
// dot-product pipeline (difference, product, sum and sign) that takes one
// plane per cycle, and stops at the first plane that hits; the verdict then
// enters the result register once that register is free or being popped.
// plane_count above 8 tests all 8 planes; op code 3 is taken and dropped. Test
// only planes that were written; the plane table has no reset.
module cut_plane_halfspace_test
   import cpht_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic [OP_BITS-1:0]           req_op,
   input  logic [INDEX_BITS-1:0]        req_plane_index,
   input  logic signed [COORD_BITS-1:0] req_ax,
   input  logic signed [COORD_BITS-1:0] req_ay,
   input  logic signed [COORD_BITS-1:0] req_az,
   input  logic signed [COORD_BITS-1:0] req_bx,
   input  logic signed [COORD_BITS-1:0] req_by,
   input  logic signed [COORD_BITS-1:0] req_bz,
   output logic                         empty,
   input  logic                         pop,
   output logic                         rsp_hit,
   output logic [INDEX_BITS-1:0]        rsp_hit_plane,
   input  logic                         csr_write_en,
   input  logic [COUNT_BITS-1:0]        csr_write_data
);

   qstat_type q_stat;
   cmd_type   q_data;
   cmd_type   q_head;
   logic      q_push;
   logic      q_pop;

   // accept and classify
   cpht_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_op          (req_op),
      .req_plane_index (req_plane_index),
      .req_ax          (req_ax),
      .req_ay          (req_ay),
      .req_az          (req_az),
      .req_bx          (req_bx),
      .req_by          (req_by),
      .req_bz          (req_bz),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .q_stat          (q_stat),
      .q_push          (q_push),
      .q_data          (q_data)
   );

   // command queue
   cpht_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_data (q_data),
      .q_pop  (q_pop),
      .q_head (q_head),
      .q_stat (q_stat)
   );

   // plane table and test engine
   cpht_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_head        (q_head),
      .q_stat        (q_stat),
      .q_pop         (q_pop),
      .empty         (empty),
      .pop           (pop),
      .rsp_hit       (rsp_hit),
      .rsp_hit_plane (rsp_hit_plane)
   );

   // checks
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !q_push)
      else $error("command pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("command popped from an empty queue");

   a_miss_plane_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_hit) |-> (rsp_hit_plane == '0))
      else $error("plane index nonzero on a miss");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

// one input beat as driven on the req_ ports
typedef struct packed {
   logic [cpht_pkg::OP_BITS-1:0]           op;
   logic [cpht_pkg::INDEX_BITS-1:0]        plane_index;
   logic signed [cpht_pkg::COORD_BITS-1:0] ax;
   logic signed [cpht_pkg::COORD_BITS-1:0] ay;
   logic signed [cpht_pkg::COORD_BITS-1:0] az;
   logic signed [cpht_pkg::COORD_BITS-1:0] bx;
   logic signed [cpht_pkg::COORD_BITS-1:0] by;
   logic signed [cpht_pkg::COORD_BITS-1:0] bz;
} plane_item_type;

// one expected cut verdict
typedef struct packed {
   logic                              hit;
   logic [cpht_pkg::INDEX_BITS-1:0]   plane;
} cut_verdict_type;

// plane table copy plus the queue of verdicts still owed by the block
class cut_verdict_board;
   logic signed [cpht_pkg::COORD_BITS-1:0] nrm_x [cpht_pkg::MAX_PLANES];
   logic signed [cpht_pkg::COORD_BITS-1:0] nrm_y [cpht_pkg::MAX_PLANES];
   logic signed [cpht_pkg::COORD_BITS-1:0] nrm_z [cpht_pkg::MAX_PLANES];
   logic signed [cpht_pkg::COORD_BITS-1:0] pt_x [cpht_pkg::MAX_PLANES];
   logic signed [cpht_pkg::COORD_BITS-1:0] pt_y [cpht_pkg::MAX_PLANES];
   logic signed [cpht_pkg::COORD_BITS-1:0] pt_z [cpht_pkg::MAX_PLANES];
   logic [cpht_pkg::COUNT_BITS-1:0]        active_count;
   cut_verdict_type                        verdicts_due [$];
   int                                     fails;

   function new();
      active_count = '0;
      fails = 0;
   endfunction

   task report(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      fails++;
   endtask

   function void set_count(logic [cpht_pkg::COUNT_BITS-1:0] c);
      active_count = c;
   endfunction

   function int pending();
      return verdicts_due.size();
   endfunction

   // exact sign of dot(normal, v - point) for plane k
   function bit above_plane(int k, logic signed [cpht_pkg::COORD_BITS-1:0] vx,
                            logic signed [cpht_pkg::COORD_BITS-1:0] vy,
                            logic signed [cpht_pkg::COORD_BITS-1:0] vz);
      logic signed [cpht_pkg::DIFF_BITS-1:0] dx, dy, dz;
      logic signed [cpht_pkg::SUM_BITS-1:0]  dot;
      dx = {vx[cpht_pkg::COORD_BITS-1], vx} - {pt_x[k][cpht_pkg::COORD_BITS-1], pt_x[k]};
      dy = {vy[cpht_pkg::COORD_BITS-1], vy} - {pt_y[k][cpht_pkg::COORD_BITS-1], pt_y[k]};
      dz = {vz[cpht_pkg::COORD_BITS-1], vz} - {pt_z[k][cpht_pkg::COORD_BITS-1], pt_z[k]};
      dot = nrm_x[k] * dx + nrm_y[k] * dy + nrm_z[k] * dz;
      return dot > 0;
   endfunction

   // accepted beat: update the table or queue the verdict it causes
   function void note_item(plane_item_type it);
      int              lim;
      bit              side;
      cut_verdict_type v;
      case (it.op)
         cpht_pkg::OP_WRITE: begin
            nrm_x[it.plane_index] = it.ax;
            nrm_y[it.plane_index] = it.ay;
            nrm_z[it.plane_index] = it.az;
            pt_x[it.plane_index]  = it.bx;
            pt_y[it.plane_index]  = it.by;
            pt_z[it.plane_index]  = it.bz;
         end
         cpht_pkg::OP_POINT, cpht_pkg::OP_SEGMENT: begin
            lim = (active_count > cpht_pkg::MAX_PLANES) ? cpht_pkg::MAX_PLANES
                                                        : int'(active_count);
            v = '0;
            for (int k = 0; k < lim; k++) begin
               side = above_plane(k, it.ax, it.ay, it.az);
               if (it.op == cpht_pkg::OP_SEGMENT)
                  side = side ^ above_plane(k, it.bx, it.by, it.bz);
               if (side && !v.hit) begin
                  v.hit   = 1'b1;
                  v.plane = 3'(k);
               end
            end
            verdicts_due.insert(verdicts_due.size(), v);
         end
         default: ;
      endcase
   endfunction

   task check_verdict(logic hit, logic [cpht_pkg::INDEX_BITS-1:0] plane);
      cut_verdict_type v;
      if (verdicts_due.size() == 0) begin
         report("result beat with nothing expected");
      end else begin
         v = verdicts_due.pop_front();
         if (hit !== v.hit)
            report($sformatf("hit got %b want %b", hit, v.hit));
         if (plane !== v.plane)
            report($sformatf("hit_plane got %0d want %0d", plane, v.plane));
      end
   endtask
endclass

module tb;
   import cpht_pkg::*;

   localparam int DRAIN_CYCLES = 40;
   localparam int END_WAIT     = 50000;
   localparam int ITEMS_PER_BLOCK = 62;
   localparam logic signed [COORD_BITS-1:0] ONE  = 32'sh0001_0000;
   localparam logic signed [COORD_BITS-1:0] CMAX = 32'sh7fff_ffff;
   localparam logic signed [COORD_BITS-1:0] CMIN = 32'sh8000_0000;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         push = 1'b0;
   logic                         pop = 1'b0;
   logic [OP_BITS-1:0]           req_op = '0;
   logic [INDEX_BITS-1:0]        req_plane_index = '0;
   logic signed [COORD_BITS-1:0] req_ax = '0;
   logic signed [COORD_BITS-1:0] req_ay = '0;
   logic signed [COORD_BITS-1:0] req_az = '0;
   logic signed [COORD_BITS-1:0] req_bx = '0;
   logic signed [COORD_BITS-1:0] req_by = '0;
   logic signed [COORD_BITS-1:0] req_bz = '0;
   logic                         csr_write_en = 1'b0;
   logic [COUNT_BITS-1:0]        csr_write_data = '0;
   logic                         full;
   logic                         empty;
   logic                         rsp_hit;
   logic [INDEX_BITS-1:0]        rsp_hit_plane;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   // nested slab table: planes along one axis with evenly spaced thresholds
   bit slab_mode = 1'b0;
   int slab_axis = 0;
   int slab_sign = 1;
   int slab_step = 1;

   cut_verdict_board board;

   cut_plane_halfspace_test dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_op          (req_op),
      .req_plane_index (req_plane_index),
      .req_ax          (req_ax),
      .req_ay          (req_ay),
      .req_az          (req_az),
      .req_bx          (req_bx),
      .req_by          (req_by),
      .req_bz          (req_bz),
      .empty           (empty),
      .pop             (pop),
      .rsp_hit         (rsp_hit),
      .rsp_hit_plane   (rsp_hit_plane),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data)
   );

   always #5 clock = ~clock;

   // hard stop
   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // result side: check each popped beat, then stall at random
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty)
            board.check_verdict(rsp_hit, rsp_hit_plane);
         pop <= !reset && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic signed [COORD_BITS-1:0] rand_coord();
      case ($urandom_range(9))
         0: return CMAX;
         1: return CMIN;
         2: return 32'sd0;
         3: return -32'sd1;
         4, 5: return int'($urandom_range(512)) - 256;
         6, 7: return $signed($urandom) >>> $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   function automatic plane_item_type make_item(logic [OP_BITS-1:0] op,
                                                logic [INDEX_BITS-1:0] idx,
                                                logic signed [COORD_BITS-1:0] ax,
                                                logic signed [COORD_BITS-1:0] ay,
                                                logic signed [COORD_BITS-1:0] az,
                                                logic signed [COORD_BITS-1:0] bx,
                                                logic signed [COORD_BITS-1:0] by,
                                                logic signed [COORD_BITS-1:0] bz);
      plane_item_type it;
      it.op = op;
      it.plane_index = idx;
      it.ax = ax;
      it.ay = ay;
      it.az = az;
      it.bx = bx;
      it.by = by;
      it.bz = bz;
      return it;
   endfunction

   // drive one beat, holding push until it is taken
   task automatic push_item(plane_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      req_op          <= it.op;
      req_plane_index <= it.plane_index;
      req_ax          <= it.ax;
      req_ay          <= it.ay;
      req_az          <= it.az;
      req_bx          <= it.bx;
      req_by          <= it.by;
      req_bz          <= it.bz;
      push            <= 1'b1;
      @(posedge clock);
      while (full)
         @(posedge clock);
      board.note_item(it);
   endtask

   // wait for all verdicts, then let writes and dropped beats drain
   task automatic settle();
      push <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(logic [COUNT_BITS-1:0] c);
      settle();
      csr_write_en   <= 1'b1;
      csr_write_data <= c;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      board.set_count(c);
   endtask

   // fill the table with nested slabs so hits land on every plane index
   task automatic load_slabs();
      logic signed [COORD_BITS-1:0] n [3];
      logic signed [COORD_BITS-1:0] p [3];
      slab_axis = $urandom_range(2);
      slab_sign = $urandom_range(1) ? 1 : -1;
      slab_step = $urandom_range(1, 1 << 20);
      for (int k = 0; k < MAX_PLANES; k++) begin
         for (int j = 0; j < 3; j++) begin
            n[j] = (j == slab_axis) ? slab_sign * ONE : 32'sd0;
            p[j] = (j == slab_axis) ? slab_sign * (MAX_PLANES - k) * slab_step
                                    : rand_coord();
         end
         push_item(make_item(OP_WRITE, 3'(k), n[0], n[1], n[2], p[0], p[1], p[2]));
      end
   endtask

   task automatic random_item();
      logic signed [COORD_BITS-1:0] a [3];
      logic signed [COORD_BITS-1:0] b [3];
      logic [OP_BITS-1:0]           op;
      int                           r;
      int                           k;
      r = $urandom_range(99);
      for (int j = 0; j < 3; j++) begin
         a[j] = rand_coord();
         b[j] = rand_coord();
      end
      if (r < (slab_mode ? 4 : 15)) begin
         op = OP_WRITE;
      end else if (r < 20) begin
         op = OP_NONE;
      end else begin
         op = $urandom_range(1) ? OP_POINT : OP_SEGMENT;
         k = $urandom_range(MAX_PLANES - 1);
         if (slab_mode) begin
            a[slab_axis] = slab_sign * int'($urandom_range(9 * slab_step));
            b[slab_axis] = slab_sign * int'($urandom_range(9 * slab_step));
         end else if ($urandom_range(99) < 35) begin
            // on or next to a plane point: dot near zero
            a[0] = board.pt_x[k];
            a[1] = board.pt_y[k];
            a[2] = board.pt_z[k];
            r = $urandom_range(2);
            a[r] = a[r] + int'($urandom_range(4)) - 2;
         end
         if ($urandom_range(3) == 0)
            b = a;
      end
      push_item(make_item(op, INDEX_BITS'($urandom_range(MAX_PLANES - 1)),
                          a[0], a[1], a[2], b[0], b[1], b[2]));
   endtask

   initial begin
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // no active planes: never a hit
      push_item(make_item(OP_POINT, 3'd0, CMAX, CMIN, 32'sd0, CMIN, CMAX, -32'sd1));
      push_item(make_item(OP_SEGMENT, 3'd7, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
      push_item(make_item(OP_NONE, 3'd7, -32'sd1, -32'sd1, -32'sd1,
                          -32'sd1, -32'sd1, -32'sd1));

      // load every entry, extremes among them
      push_item(make_item(OP_WRITE, 3'd0, ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
      push_item(make_item(OP_WRITE, 3'd1, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
      push_item(make_item(OP_WRITE, 3'd2, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
      push_item(make_item(OP_WRITE, 3'd3, 32'sd0, 32'sd0, 32'sd0,
                          rand_coord(), rand_coord(), rand_coord()));
      push_item(make_item(OP_WRITE, 3'd4, 32'sd0, -ONE, 32'sd0, 32'sd0, 5 * ONE, 32'sd0));
      for (int k = 5; k < MAX_PLANES; k++)
         push_item(make_item(OP_WRITE, 3'(k), rand_coord(), rand_coord(), rand_coord(),
                             rand_coord(), rand_coord(), rand_coord()));

      // full table
      write_count(4'd8);
      push_item(make_item(OP_POINT, 3'd0, 32'sd0, 32'sd0, 32'sd0, CMAX, CMAX, CMAX));
      push_item(make_item(OP_POINT, 3'd5, ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
      push_item(make_item(OP_POINT, 3'd0, CMAX, CMAX, CMAX, 32'sd0, 32'sd0, 32'sd0));
      push_item(make_item(OP_POINT, 3'd0, CMIN, CMIN, CMIN, 32'sd0, 32'sd0, 32'sd0));
      push_item(make_item(OP_SEGMENT, 3'd0, -ONE, 32'sd0, 32'sd0, ONE, 32'sd0, 32'sd0));
      push_item(make_item(OP_SEGMENT, 3'd0, 32'sd7, 32'sd7, 32'sd7,
                          32'sd7, 32'sd7, 32'sd7));
      push_item(make_item(OP_SEGMENT, 3'd0, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));

      // count above the table size
      write_count(4'd15);
      push_item(make_item(OP_POINT, 3'd0, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX));
      push_item(make_item(OP_SEGMENT, 3'd0, 32'sd0, 6 * ONE, 32'sd0, 32'sd0, ONE, 32'sd0));

      // single plane
      write_count(4'd1);
      push_item(make_item(OP_POINT, 3'd0, CMAX, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0));

      // random part in four idling phases
      for (int phase = 0; phase < 4; phase++) begin
         settle();
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
         endcase
         for (int blk = 0; blk < 3; blk++) begin
            if (blk == 0) begin
               case (phase)
                  0: write_count(4'd0);
                  1: write_count(4'd15);
                  2: write_count(4'd8);
                  default: write_count(4'd1);
               endcase
            end else begin
               write_count(COUNT_BITS'($urandom_range(15)));
            end
            slab_mode = ($urandom_range(1) != 0);
            if (slab_mode)
               load_slabs();
            for (int i = 0; i < ITEMS_PER_BLOCK; i++)
               random_item();
         end
      end

      // drain and finish
      push <= 1'b0;
      for (int i = 0; i < END_WAIT && board.pending() != 0; i++)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.pending() != 0)
         board.report($sformatf("%0d results never arrived", board.pending()));
      if (board.fails == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
